/* rtl/core/counter_priority_task_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the counter priority task scheduler
// Implication checks, same cycle and next cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define CPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define CPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define CPTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/cpts_pkg.sv */
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared constants and types of the counter priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

  localparam int NUM_TASKS = 8;                 // 2 .. 64
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = 8;
  localparam int TASK_W    = 6;                 // fixed field width
  localparam int OP_W      = 1;

  localparam logic [OP_W-1:0] OP_TICK = 1'b0;
  localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

  // candidate passed down the cell chain
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } cand_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             dec_en;
    logic [IDX_W-1:0] dec_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] wr_val;
    logic             reload;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cpts_cell.sv */
// ----------------------------------------------------------------------------
// cpts_cell
// One task slot: priority, slice counter and one stage of the max scan.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [cpts_pkg::IDX_W-1:0]   my_idx,
  input  wire cpts_pkg::cell_ctl_t          ctl,
  input  wire cpts_pkg::cand_t              cand_in,
  output cpts_pkg::cand_t                   cand_out,
  output logic [cpts_pkg::CNT_W-1:0]        cnt
);
  import cpts_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] prio_r, prio_nxt;
  cand_t            cand_r, cand_nxt;

  always_comb begin
    prio_nxt = prio_r;
    if (ctl.wr_en && ctl.wr_idx == my_idx) begin
      prio_nxt = ctl.wr_val;
    end
    cnt_nxt = cnt_r;
    if (ctl.reload) begin
      cnt_nxt = prio_r;
    end else if (ctl.dec_en && ctl.dec_idx == my_idx && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    // strict compare: on a tie the higher slot upstream keeps the lead
    if (cnt_r > cand_in.cnt) begin
      cand_nxt.idx = my_idx;
      cand_nxt.cnt = cnt_r;
    end else begin
      cand_nxt = cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prio_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      prio_r <= prio_nxt;
    end
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;
  assign cnt      = cnt_r;

endmodule

`default_nettype wire

/* rtl/core/counter_priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Time-slice scheduler: a chain of task cells with a max-counter scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item transfers when start is high and busy is low. opcode 1
//   loads the priority of slot in_task_index; opcode 0 is one timer tick.
//   Output: every item yields one result, shown for one cycle with
//   out_valid high; the receiver cannot stall it.
// Flow:
//   A load, or a tick that leaves a nonzero slice, returns its result in
//   the cycle after the transfer and a new item may start in that cycle.
//   A tick that needs a pick waits for the scan to ripple through the cell
//   chain (one cell per cycle) and then compares; with a refill from the
//   priorities the scan runs twice.
//   busy stays high during the scan; the next item may transfer in the
//   cycle that the result is shown.
// Reset:
//   Synchronous, active low: all counters and priorities clear and the
//   idle task (slot 0) is running.
// ----------------------------------------------------------------------------
`default_nettype none
`include "counter_priority_task_scheduler_macros.svh"

module counter_priority_task_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cpts_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [cpts_pkg::TASK_W-1:0]   in_task_index,
  input  wire logic [cpts_pkg::CNT_W-1:0]    in_priority_value,
  output logic                               out_valid,
  output logic [cpts_pkg::TASK_W-1:0]        out_running_task,
  output logic                               out_switched,
  output logic                               out_reloaded,
  output logic [cpts_pkg::CNT_W-1:0]         out_remaining_slice,
  output logic                               out_none_ready
);
  import cpts_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t           state_r;
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] wait_r;
  logic             reload_done_r;

  logic             out_valid_r;
  logic [TASK_W-1:0] out_task_r;
  logic             out_switched_r;
  logic             out_reloaded_r;
  logic [CNT_W-1:0] out_slice_r;
  logic             out_none_r;

  cell_ctl_t        ctl;
  cand_t            cand_w [1:NUM_TASKS];
  logic [CNT_W-1:0] cnt_w  [0:NUM_TASKS-1];
  logic [CNT_W-1:0] cur_cnt;
  logic             accept;
  logic             idx_ok;
  cand_t            best;

  assign accept  = start && !busy;
  assign idx_ok  = {1'b0, in_task_index} < (TASK_W+1)'(NUM_TASKS);
  assign cur_cnt = cnt_w[cur_r];
  assign best    = cand_w[1];

  // idle slot never holds a slice
  assign cand_w[NUM_TASKS] = '0;
  assign cnt_w[0]          = '0;

  for (genvar k = 1; k < NUM_TASKS; k++) begin : g_cell
    cpts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (IDX_W'(k)),
      .ctl      (ctl),
      .cand_in  (cand_w[k+1]),
      .cand_out (cand_w[k]),
      .cnt      (cnt_w[k])
    );
  end

  always_comb begin
    ctl.dec_en  = accept && in_opcode == OP_TICK;
    ctl.dec_idx = cur_r;
    ctl.wr_en   = accept && in_opcode == OP_LOAD && idx_ok;
    ctl.wr_idx  = in_task_index[IDX_W-1:0];
    ctl.wr_val  = in_priority_value;
    ctl.reload  = state_r == ST_SCAN && wait_r == '0 && best.cnt == '0 && !reload_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_r         <= '0;
      wait_r        <= '0;
      reload_done_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_opcode == OP_LOAD || cur_cnt > CNT_W'(1)) begin
              out_valid_r    <= 1'b1;
              out_task_r     <= TASK_W'(cur_r);
              out_switched_r <= 1'b0;
              out_reloaded_r <= 1'b0;
              out_none_r     <= 1'b0;
              out_slice_r    <= (in_opcode == OP_LOAD) ? cur_cnt : cur_cnt - 1'b1;
            end else begin
              // slice used up: wait for the chain to settle
              state_r       <= ST_SCAN;
              wait_r        <= IDX_W'(NUM_TASKS - 1);
              reload_done_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - 1'b1;
          end else if (best.cnt != '0) begin
            cur_r          <= best.idx;
            out_valid_r    <= 1'b1;
            out_task_r     <= TASK_W'(best.idx);
            out_switched_r <= best.idx != cur_r;
            out_reloaded_r <= reload_done_r;
            out_none_r     <= 1'b0;
            out_slice_r    <= best.cnt;
            state_r        <= ST_IDLE;
          end else if (!reload_done_r) begin
            // refill happens through ctl.reload; rescan
            reload_done_r <= 1'b1;
            wait_r        <= IDX_W'(NUM_TASKS - 1);
          end else begin
            out_valid_r    <= 1'b1;
            out_task_r     <= TASK_W'(cur_r);
            out_switched_r <= 1'b0;
            out_reloaded_r <= 1'b1;
            out_none_r     <= 1'b1;
            out_slice_r    <= cur_cnt;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy                = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_running_task    = out_task_r;
  assign out_switched        = out_switched_r;
  assign out_reloaded        = out_reloaded_r;
  assign out_remaining_slice = out_slice_r;
  assign out_none_ready      = out_none_r;

  `CPTS_ASSERT_NEXT(a_accept_resolves, clk, rst_n, accept, out_valid || busy)
  `CPTS_ASSERT_SAME(a_none_ready_flags, clk, rst_n, out_valid && out_none_ready, out_reloaded && out_remaining_slice == '0 && !out_switched)
  `CPTS_ASSERT_SAME(a_switch_has_slice, clk, rst_n, out_valid && out_switched, out_remaining_slice != '0 && out_running_task != '0)

endmodule

`default_nettype wire
